>>> rtl/core/pcfc_pkg.sv
package pcfc_pkg;

  localparam int MAX_PAYLOAD_BYTES = 4096;
  localparam int CNT_W             = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int DSUM_W            = 21;
  localparam int TAPS_W            = 13;
  localparam int ADDR_W            = 4;

  localparam logic [31:0] CRC_POLY     = 32'hedb8_8320;
  localparam logic [31:0] CRC_INIT     = 32'hffff_ffff;
  localparam logic [7:0]  OP_END       = 8'h00;
  localparam logic [7:0]  OP_DELAY     = 8'h01;
  localparam logic [7:0]  OP_TAP       = 8'h02;
  localparam logic [7:0]  USAGE_MIN    = 8'h04;
  localparam logic [7:0]  USAGE_MAX    = 8'h65;
  localparam logic [15:0] DELAY_MAX_MS = 16'd10000;

  localparam logic [31:0] EXPECTED_CRC_RST = 32'd0;
  localparam logic [19:0] DELAY_LIMIT_RST  = 20'd60000;
  localparam logic [11:0] TAP_LIMIT_RST    = 12'd1000;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_CRC      = 4'd1,
    ST_TRAILING = 4'd2,
    ST_TRUNC    = 4'd3,
    ST_DRANGE   = 4'd4,
    ST_DLIMIT   = 4'd5,
    ST_USAGE    = 4'd6,
    ST_TAPS     = 4'd7,
    ST_OPCODE   = 4'd8,
    ST_NOEND    = 4'd9,
    ST_LENGTH   = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    POS_OPCODE = 2'd0,
    POS_FIRST  = 2'd1,
    POS_SECOND = 2'd2,
    POS_ENDED  = 2'd3
  } pos_e;

  typedef enum logic [1:0] {
    REG_EXPECTED_CRC = 2'd0,
    REG_DELAY_LIMIT  = 2'd1,
    REG_TAP_LIMIT    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] expected_crc;
    logic [19:0] total_delay_limit;
    logic [11:0] tap_limit;
  } cfg_t;

  typedef struct packed {
    logic        final_res;
    status_e     status;
    logic [31:0] checksum;
  } res_t;

  // reflected CRC-32, one byte, bit at a time
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> rtl/core/pcfc_if.sv
interface pcfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface pcfc_out_if;
  logic        valid;
  logic        ready;
  logic        final_res;
  logic [3:0]  status;
  logic [31:0] checksum;

  modport source (output valid, output final_res, output status, output checksum,
                  input ready);
  modport sink (input valid, input final_res, input status, input checksum,
                output ready);
endinterface

>>> rtl/core/pcfc_engine.sv
module pcfc_engine
  import pcfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] payload_byte_i,
  input  logic       last_byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  logic [31:0]       crc_q, crc_d;
  pos_e              pos_q, pos_d;
  logic              is_delay_q, is_delay_d;
  logic [7:0]        held_q, held_d;
  logic [DSUM_W-1:0] dsum_q, dsum_d;
  logic [TAPS_W-1:0] taps_q, taps_d;
  status_e           err_q, err_d, err_pre;
  logic [CNT_W-1:0]  count_q, count_d;

  logic [31:0]       sum;
  logic [15:0]       delay_val;
  logic [DSUM_W-1:0] dsum_add;
  logic [TAPS_W-1:0] taps_add;
  logic              too_long;

  assign crc_d     = crc_byte(crc_q, payload_byte_i);
  assign sum       = ~crc_d;
  assign delay_val = {held_q, payload_byte_i};
  assign dsum_add  = dsum_q + DSUM_W'(delay_val);
  assign taps_add  = taps_q + TAPS_W'(1);
  assign too_long  = (count_q >= CNT_W'(MAX_PAYLOAD_BYTES));

  // next state: length check, then instruction parse while no error
  always_comb begin
    pos_d      = pos_q;
    is_delay_d = is_delay_q;
    held_d     = held_q;
    dsum_d     = dsum_q;
    taps_d     = taps_q;
    count_d    = count_q;
    err_pre    = err_q;
    if (too_long) begin
      err_pre = ST_LENGTH;
    end else begin
      count_d = count_q + CNT_W'(1);
    end
    err_d = err_pre;
    if (err_pre == ST_OK) begin
      unique case (pos_q)
        POS_OPCODE: begin
          if (payload_byte_i == OP_END) begin
            pos_d = POS_ENDED;
          end else if (payload_byte_i == OP_DELAY || payload_byte_i == OP_TAP) begin
            is_delay_d = (payload_byte_i == OP_DELAY);
            pos_d      = POS_FIRST;
          end else begin
            err_d = ST_OPCODE;
          end
        end
        POS_FIRST: begin
          held_d = payload_byte_i;
          pos_d  = POS_SECOND;
        end
        POS_SECOND: begin
          pos_d = POS_OPCODE;
          if (is_delay_q) begin
            if (delay_val == 16'd0 || delay_val > DELAY_MAX_MS) begin
              err_d = ST_DRANGE;
            end else begin
              dsum_d = dsum_add;
              if (dsum_add > DSUM_W'(cfg_i.total_delay_limit)) begin
                err_d = ST_DLIMIT;
              end
            end
          end else begin
            if (payload_byte_i < USAGE_MIN || payload_byte_i > USAGE_MAX) begin
              err_d = ST_USAGE;
            end else begin
              taps_d = taps_add;
              if (taps_add > TAPS_W'(cfg_i.tap_limit)) begin
                err_d = ST_TAPS;
              end
            end
          end
        end
        POS_ENDED: begin
          err_d = ST_TRAILING;
        end
        default: begin
          err_d = ST_TRAILING;
        end
      endcase
    end
  end

  // result: running status, or the final verdict on the last byte
  always_comb begin
    res_o.final_res = last_byte_i;
    res_o.checksum  = sum;
    res_o.status    = err_d;
    if (last_byte_i) begin
      priority if (err_d == ST_LENGTH) begin
        res_o.status = ST_LENGTH;
      end else if (sum != cfg_i.expected_crc) begin
        res_o.status = ST_CRC;
      end else if (err_d != ST_OK) begin
        res_o.status = err_d;
      end else if (pos_d == POS_ENDED) begin
        res_o.status = ST_OK;
      end else if (pos_d == POS_OPCODE) begin
        res_o.status = ST_NOEND;
      end else begin
        res_o.status = ST_TRUNC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CRC_INIT;
      pos_q      <= POS_OPCODE;
      is_delay_q <= 1'b0;
      held_q     <= 8'd0;
      dsum_q     <= '0;
      taps_q     <= '0;
      err_q      <= ST_OK;
      count_q    <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        crc_q      <= CRC_INIT;
        pos_q      <= POS_OPCODE;
        is_delay_q <= 1'b0;
        held_q     <= 8'd0;
        dsum_q     <= '0;
        taps_q     <= '0;
        err_q      <= ST_OK;
        count_q    <= '0;
      end else begin
        crc_q      <= crc_d;
        pos_q      <= pos_d;
        is_delay_q <= is_delay_d;
        held_q     <= held_d;
        dsum_q     <= dsum_d;
        taps_q     <= taps_d;
        err_q      <= err_d;
        count_q    <= count_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> count_q == '0 && pos_q == POS_OPCODE && err_q == ST_OK
                                && crc_q == CRC_INIT)
    else $error("state not cleared after last byte");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_PAYLOAD_BYTES))
    else $error("byte count past maximum");

  a_length_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !last_byte_i && too_long |=> err_q == ST_LENGTH)
    else $error("length error not latched");
`endif

endmodule

>>> rtl/core/pcfc_skid.sv
module pcfc_skid
  import pcfc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic push, pop;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = main_valid_q && out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push;
        main_d       = in_data_i;
      end
    end else if (push) begin
      if (!main_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = in_data_i;
      end else begin
        // output stalled: park the transfer in the skid slot
        skid_valid_d = 1'b1;
        skid_d       = in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid slot full while output slot empty");

  a_park_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && main_valid_q && !out_ready_i |=> skid_valid_q && skid_q == $past(in_data_i))
    else $error("stalled transfer not parked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
`endif

endmodule

>>> rtl/core/payload_crc_and_format_check.sv
// Payload CRC-32 and instruction format checker.
// in_i carries one payload byte per transfer with a flag on the last byte.
// Every accepted byte yields exactly one result on out_o: final_res, status
// and the complemented CRC-32 over the bytes so far. Before the last byte,
// status shows the first format error or a later length error; on the last byte it
// is the final verdict and the checker returns to its cleared state.
// Each result is registered in the output slot of the skid buffer before it
// appears on out_o. Throughput is one byte per cycle while in_i.ready is high;
// the CRC byte step and the operand checks both finish within the cycle between the input
// handshake and the result register.
// When out_o stalls, one more result is held in a skid slot, and in_i.ready
// drops only once that slot is full; no result is lost or repeated.
// Reset clears CRC and parse state and loads the registers with their
// defaults (expected CRC 0, delay limit 60000 ms, tap limit 1000).
// APB registers: 0x0 expected CRC, 0x4 total delay limit, 0x8 tap limit;
// write them only while no payload is in progress.
module payload_crc_and_format_check
  import pcfc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  pcfc_in_if.sink           in_i,
  pcfc_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg_q;
  res_t res, out_res;
  logic in_ready, accept, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_crc      <= EXPECTED_CRC_RST;
      cfg_q.total_delay_limit <= DELAY_LIMIT_RST;
      cfg_q.tap_limit         <= TAP_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_EXPECTED_CRC: cfg_q.expected_crc      <= pwdata;
        REG_DELAY_LIMIT:  cfg_q.total_delay_limit <= pwdata[19:0];
        REG_TAP_LIMIT:    cfg_q.tap_limit         <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_EXPECTED_CRC: prdata = cfg_q.expected_crc;
      REG_DELAY_LIMIT:  prdata = {12'd0, cfg_q.total_delay_limit};
      REG_TAP_LIMIT:    prdata = {20'd0, cfg_q.tap_limit};
      default:          prdata = 32'd0;
    endcase
  end

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  pcfc_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .payload_byte_i (in_i.payload_byte),
    .last_byte_i    (in_i.last_byte),
    .cfg_i          (cfg_q),
    .res_o          (res)
  );

  pcfc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_data_i   (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_res)
  );

  assign out_o.final_res = out_res.final_res;
  assign out_o.status    = out_res.status;
  assign out_o.checksum  = out_res.checksum;

endmodule
